>>> hw/rtl/mlqs_pkg.sv
// mlqs_pkg: shared sizes, codes and controller/datapath interface types
// for the multilevel queue scheduler. No dependencies.
package mlqs_pkg;

  localparam int LEVELS  = 4;
  localparam int TASKS   = 16;
  localparam int MAX_RES = 16;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int POS_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CNT_W   = $clog2(TASKS + 1);
  localparam int ADDR_W  = LVL_W + POS_W;
  // entry: timeout mark, task id, active time
  localparam int ENT_W   = 21;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_DISP = 2'd1;
  localparam logic [1:0] ACT_TMO  = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam logic [2:0] KIND_ADDED = 3'd0;
  localparam logic [2:0] KIND_REJ   = 3'd1;
  localparam logic [2:0] KIND_DISP  = 3'd2;
  localparam logic [2:0] KIND_EMPTY = 3'd3;
  localparam logic [2:0] KIND_TMO   = 3'd4;
  localparam logic [2:0] KIND_NOTMO = 3'd5;

  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_CHK, S_ADD_REJ, S_ADD_RD, S_ADD_CMP, S_ADD_ACK,
    S_DSP_CHK, S_DSP_HEAD, S_DSP_RD, S_DSP_MOVE, S_DSP_ACK, S_DSP_EMPTY,
    S_TMO_INIT, S_TMO_RD, S_TMO_CHK, S_CMP_INIT, S_CMP_RD, S_CMP_WR, S_TMO_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ADD_INIT, OP_ADD_RD, OP_ADD_PUT, OP_ADD_MOVE,
    OP_EMIT_REJ, OP_EMIT_ADD, OP_DSP_INIT, OP_DSP_HEAD, OP_DSP_RD, OP_DSP_MOVE,
    OP_DSP_DEC, OP_EMIT_DSP, OP_EMIT_EMPTY, OP_TMO_INIT, OP_TMO_RD, OP_TMO_CHK,
    OP_TMO_NEXT, OP_CMP_INIT, OP_CMP_RD, OP_CMP_WR, OP_CMP_NEXT, OP_EMIT_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic add_ok;
    logic pos_zero;
    logic stop;
    logic any;
    logic idx_end;
    logic scan_last;
    logic lv_last;
    logic tmo_stall;
    logic out_free;
  } stat_t;

endpackage

>>> hw/rtl/multilevel_queue_scheduler.sv
// multilevel_queue_scheduler: top level, APB register port and the ctrl/datapath pair.
// Depends on mlqs_pkg, mlqs_ctrl, mlqs_dpath and mlqs_ram.
//
// Requests arrive on the in_ stream: tuser carries the action (add, dispatch,
// timeout check), tdata the task fields. Results leave on the out_ stream with
// the result kind in tuser and tlast on the final result of each request.
// Ready queues live in one RAM of LEVELS*TASKS entries with registered read.
// One request is worked at a time; in_tready is high only while idle, but a
// new request is taken while the previous result still waits on out_.
// An add shifts entries toward the tail until it finds its slot; a dispatch moves
// the rest of its level up by one. A timeout check scans the queue RAM per task
// ID through its single read port, then compacts each level.
// A stalled receiver holds the result register and the sequencer waits at its
// next result. Synchronous reset empties all queues (counts cleared), sets
// timeout_limit to 20 and lowest_user_level to 3; no clearing pass is needed.
// Registers: 0x0 timeout_limit, 0x4 lowest_user_level; pready is always high.
module multilevel_queue_scheduler import mlqs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // task_id, level, demote, active_time, current_time
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // task_id_res, level_res, active_time_res
  output logic [2:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  cmd_t  cmd;
  stat_t st;
  logic  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  mlqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  mlqs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr     (cfg_wr),
    .cfg_idx    (cfg_paddr[2]),
    .cfg_wdata  (cfg_pwdata),
    .cfg_rdata  (cfg_prdata)
  );
endmodule

>>> hw/rtl/mlqs_ram.sv
// mlqs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mlqs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> hw/rtl/mlqs_ctrl.sv
// mlqs_ctrl: sequencing state machine for add, dispatch and timeout check.
// Depends on mlqs_pkg; drives the datapath through cmd_t and reads stat_t.
module mlqs_ctrl import mlqs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_tuser,
  output logic       in_tready,
  input  stat_t      st,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = OP_LOAD;
          unique case (in_tuser)
            ACT_ADD:  state_nxt = S_ADD_CHK;
            ACT_DISP: state_nxt = S_DSP_CHK;
            ACT_TMO:  state_nxt = S_TMO_INIT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_CHK: begin
        if (!st.add_ok) begin
          state_nxt = S_ADD_REJ;
        end else begin
          cmd.op    = OP_ADD_INIT;
          state_nxt = S_ADD_RD;
        end
      end
      S_ADD_REJ: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT_REJ;
          state_nxt = S_IDLE;
        end
      end
      S_ADD_RD: begin
        if (st.pos_zero) begin
          cmd.op    = OP_ADD_PUT;
          state_nxt = S_ADD_ACK;
        end else begin
          cmd.op    = OP_ADD_RD;
          state_nxt = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        if (st.stop) begin
          cmd.op    = OP_ADD_PUT;
          state_nxt = S_ADD_ACK;
        end else begin
          cmd.op    = OP_ADD_MOVE;
          state_nxt = S_ADD_RD;
        end
      end
      S_ADD_ACK: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT_ADD;
          state_nxt = S_IDLE;
        end
      end
      S_DSP_CHK: begin
        if (!st.any) begin
          state_nxt = S_DSP_EMPTY;
        end else begin
          cmd.op    = OP_DSP_INIT;
          state_nxt = S_DSP_HEAD;
        end
      end
      S_DSP_HEAD: begin
        cmd.op    = OP_DSP_HEAD;
        state_nxt = S_DSP_RD;
      end
      S_DSP_RD: begin
        if (st.idx_end) begin
          cmd.op    = OP_DSP_DEC;
          state_nxt = S_DSP_ACK;
        end else begin
          cmd.op    = OP_DSP_RD;
          state_nxt = S_DSP_MOVE;
        end
      end
      S_DSP_MOVE: begin
        cmd.op    = OP_DSP_MOVE;
        state_nxt = S_DSP_RD;
      end
      S_DSP_ACK: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT_DSP;
          state_nxt = S_IDLE;
        end
      end
      S_DSP_EMPTY: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      S_TMO_INIT: begin
        cmd.op    = OP_TMO_INIT;
        state_nxt = S_TMO_RD;
      end
      S_TMO_RD: begin
        if (st.idx_end) begin
          cmd.op = OP_TMO_NEXT;
          if (st.scan_last) begin
            state_nxt = S_CMP_INIT;
          end
        end else begin
          cmd.op    = OP_TMO_RD;
          state_nxt = S_TMO_CHK;
        end
      end
      S_TMO_CHK: begin
        if (!st.tmo_stall) begin
          cmd.op    = OP_TMO_CHK;
          state_nxt = S_TMO_RD;
        end
      end
      S_CMP_INIT: begin
        cmd.op    = OP_CMP_INIT;
        state_nxt = S_CMP_RD;
      end
      S_CMP_RD: begin
        if (st.idx_end) begin
          cmd.op = OP_CMP_NEXT;
          if (st.lv_last) begin
            state_nxt = S_TMO_FIN;
          end
        end else begin
          cmd.op    = OP_CMP_RD;
          state_nxt = S_CMP_WR;
        end
      end
      S_CMP_WR: begin
        cmd.op    = OP_CMP_WR;
        state_nxt = S_CMP_RD;
      end
      S_TMO_FIN: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/mlqs_dpath.sv
// mlqs_dpath: queue memory, counts, scan counters, config registers and result register.
// Depends on mlqs_pkg and mlqs_ram; commanded by mlqs_ctrl.
module mlqs_dpath import mlqs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] cfg_rdata
);
  logic [15:0] limit_r;
  logic [1:0]  floor_r;
  logic [3:0]  id_r;
  logic [1:0]  lvl_r;
  logic [15:0] t_r, now_r;
  logic [CNT_W-1:0] cnt_r [LEVELS];
  logic [CNT_W-1:0] pos_r, idx_r, wr_r;
  logic [LVL_W-1:0] lv_r;
  logic [3:0]  sid_r;
  logic [CNT_W-1:0] n_r;
  logic [3:0]  head_id_r;
  logic [15:0] head_t_r;
  logic        pend_v_r;
  logic [3:0]  pend_id_r;
  logic [1:0]  pend_lv_r;
  logic [15:0] pend_t_r;
  logic        ov_r, olast_r;
  logic [2:0]  okind_r;
  logic [3:0]  oid_r;
  logic [1:0]  olv_r;
  logic [15:0] ot_r;

  logic [3:0]  in_id;
  logic [1:0]  in_lvl, lvl_eff;
  logic        in_dem;
  logic [15:0] in_t, in_now;
  logic [1:0]  floor_cap;
  logic [LVL_W-1:0] li, fl;
  logic        any;
  logic [ENT_W-1:0] rd, wdata;
  logic [3:0]  rd_id;
  logic [15:0] rd_t;
  logic        rd_mark;
  logic        we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CNT_W-1:0] pm1, im1;
  logic        expired, hit, out_free;

  assign in_id  = in_tdata[3:0];
  assign in_lvl = in_tdata[5:4];
  assign in_dem = in_tdata[6];
  assign in_t   = in_tdata[22:7];
  assign in_now = in_tdata[38:23];

  always_comb begin
    floor_cap = (int'(floor_r) > LEVELS - 1) ? 2'(LEVELS - 1) : floor_r;
    lvl_eff   = in_lvl;
    if (in_dem && in_lvl != 2'd0 && in_lvl < floor_cap) begin
      lvl_eff = in_lvl + 2'd1;
    end
  end

  assign li = LVL_W'(lvl_r);

  always_comb begin
    any = 1'b0;
    fl  = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        any = 1'b1;
        fl  = LVL_W'(l);
      end
    end
  end

  assign rd_mark  = rd[ENT_W-1];
  assign rd_id    = rd[19:16];
  assign rd_t     = rd[15:0];
  assign pm1      = pos_r - 1'b1;
  assign im1      = idx_r - 1'b1;
  assign expired  = ({1'b0, rd_t} + {1'b0, limit_r}) <= {1'b0, now_r};
  assign hit      = (rd_id == sid_r) && expired && (int'(n_r) < MAX_RES);
  assign out_free = !ov_r || out_tready;

  always_comb begin
    st.add_ok    = (int'(lvl_r) < LEVELS) && (int'(cnt_r[li]) < TASKS);
    st.pos_zero  = (pos_r == '0);
    st.stop      = (rd_t < t_r) || ((rd_t == t_r) && (rd_id <= id_r));
    st.any       = any;
    st.idx_end   = (idx_r >= cnt_r[lv_r]);
    st.lv_last   = (int'(lv_r) == LEVELS - 1);
    st.scan_last = st.lv_last && (sid_r == 4'hf);
    st.tmo_stall = hit && pend_v_r && !out_free;
    st.out_free  = out_free;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rd;
    re    = 1'b0;
    raddr = {lv_r, idx_r[POS_W-1:0]};
    case (cmd.op)
      OP_ADD_RD: begin
        re    = 1'b1;
        raddr = {li, pm1[POS_W-1:0]};
      end
      OP_ADD_PUT: begin
        we    = 1'b1;
        waddr = {li, pos_r[POS_W-1:0]};
        wdata = {1'b0, id_r, t_r};
      end
      OP_ADD_MOVE: begin
        we    = 1'b1;
        waddr = {li, pos_r[POS_W-1:0]};
      end
      OP_DSP_INIT: begin
        re    = 1'b1;
        raddr = {fl, {POS_W{1'b0}}};
      end
      OP_DSP_RD, OP_TMO_RD, OP_CMP_RD: re = 1'b1;
      OP_DSP_MOVE: begin
        we    = 1'b1;
        waddr = {lv_r, im1[POS_W-1:0]};
      end
      OP_TMO_CHK: begin
        we    = hit;
        waddr = {lv_r, idx_r[POS_W-1:0]};
        wdata = {1'b1, rd[ENT_W-2:0]};
      end
      OP_CMP_WR: begin
        we    = !rd_mark;
        waddr = {lv_r, wr_r[POS_W-1:0]};
      end
      default: ;
    endcase
  end

  mlqs_ram #(.W(ENT_W), .D(2 ** ADDR_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'd20;
      floor_r <= 2'd3;
      for (int l = 0; l < LEVELS; l++) begin
        cnt_r[l] <= '0;
      end
      ov_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_idx == REG_LIMIT) begin
          limit_r <= cfg_wdata[15:0];
        end else begin
          floor_r <= cfg_wdata[1:0];
        end
      end
      if (out_tready) begin
        ov_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          id_r  <= in_id;
          lvl_r <= lvl_eff;
          t_r   <= in_t;
          now_r <= in_now;
        end
        OP_ADD_INIT: pos_r <= cnt_r[li];
        OP_ADD_PUT:  cnt_r[li] <= cnt_r[li] + 1'b1;
        OP_ADD_MOVE: pos_r <= pm1;
        OP_EMIT_REJ, OP_EMIT_ADD: begin
          ov_r    <= 1'b1;
          okind_r <= (cmd.op == OP_EMIT_ADD) ? KIND_ADDED : KIND_REJ;
          oid_r   <= id_r;
          olv_r   <= lvl_r;
          ot_r    <= t_r;
          olast_r <= 1'b1;
        end
        OP_DSP_INIT: begin
          lv_r  <= fl;
          idx_r <= CNT_W'(1);
        end
        OP_DSP_HEAD: begin
          head_id_r <= rd_id;
          head_t_r  <= rd_t;
        end
        OP_DSP_MOVE: idx_r <= idx_r + 1'b1;
        OP_DSP_DEC:  cnt_r[lv_r] <= cnt_r[lv_r] - 1'b1;
        OP_EMIT_DSP: begin
          ov_r    <= 1'b1;
          okind_r <= KIND_DISP;
          oid_r   <= head_id_r;
          olv_r   <= 2'(lv_r);
          ot_r    <= head_t_r;
          olast_r <= 1'b1;
        end
        OP_EMIT_EMPTY: begin
          ov_r    <= 1'b1;
          okind_r <= KIND_EMPTY;
          oid_r   <= '0;
          olv_r   <= '0;
          ot_r    <= '0;
          olast_r <= 1'b1;
        end
        OP_TMO_INIT: begin
          n_r      <= '0;
          sid_r    <= '0;
          lv_r     <= '0;
          idx_r    <= '0;
          pend_v_r <= 1'b0;
        end
        OP_TMO_CHK: begin
          if (hit) begin
            if (pend_v_r) begin
              ov_r    <= 1'b1;
              okind_r <= KIND_TMO;
              oid_r   <= pend_id_r;
              olv_r   <= pend_lv_r;
              ot_r    <= pend_t_r;
              olast_r <= 1'b0;
            end
            pend_v_r  <= 1'b1;
            pend_id_r <= rd_id;
            pend_lv_r <= 2'(lv_r);
            pend_t_r  <= rd_t;
            n_r <= n_r + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_TMO_NEXT: begin
          idx_r <= '0;
          if (int'(lv_r) == LEVELS - 1) begin
            lv_r  <= '0;
            sid_r <= sid_r + 4'd1;
          end else begin
            lv_r <= lv_r + 1'b1;
          end
        end
        OP_CMP_INIT: begin
          lv_r  <= '0;
          idx_r <= '0;
          wr_r  <= '0;
        end
        OP_CMP_WR: begin
          if (!rd_mark) begin
            wr_r <= wr_r + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_CMP_NEXT: begin
          cnt_r[lv_r] <= wr_r;
          lv_r        <= lv_r + 1'b1;
          idx_r       <= '0;
          wr_r        <= '0;
        end
        OP_EMIT_FIN: begin
          ov_r     <= 1'b1;
          okind_r  <= pend_v_r ? KIND_TMO : KIND_NOTMO;
          oid_r    <= pend_v_r ? pend_id_r : 4'd0;
          olv_r    <= pend_v_r ? pend_lv_r : 2'd0;
          ot_r     <= pend_v_r ? pend_t_r : 16'd0;
          olast_r  <= 1'b1;
          pend_v_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign cfg_rdata  = (cfg_idx == REG_LIMIT) ? {16'd0, limit_r} : {30'd0, floor_r};
  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, ot_r, olv_r, oid_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
endmodule

>>> hw/rtl/mlqs_chk.sv
// mlqs_chk: port-level assertions for the scheduler, bound to the top level.
// Depends on mlqs_pkg.
module mlqs_chk import mlqs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= KIND_NOTMO)
    else $error("bad result kind");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_TMO |-> out_tlast)
    else $error("single result without last");
endmodule

bind multilevel_queue_scheduler mlqs_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> test/tb_multilevel_queue_scheduler.sv
// tb_multilevel_queue_scheduler: self-checking bench for the multilevel queue scheduler,
// driving add, dispatch and timeout requests and comparing results with an in-bench model.
// Depends on mlqs_pkg and multilevel_queue_scheduler.
`timescale 1ns / 100ps

module tb_multilevel_queue_scheduler;
  import mlqs_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  id;
    logic [1:0]  lvl;
    logic [15:0] t;
    logic        last;
  } sched_res_t;

  typedef struct {
    logic [1:0]  act;
    logic [3:0]  id;
    logic [1:0]  lvl;
    logic        dem;
    logic [15:0] at;
    logic [15:0] now;
    logic        fixed;
    sched_res_t  res;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  multilevel_queue_scheduler u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // model state
  logic [3:0]  q_id [LEVELS][TASKS];
  logic [15:0] q_t  [LEVELS][TASKS];
  int unsigned q_cnt [LEVELS];
  logic [15:0] m_limit = 16'd20;
  logic [1:0]  m_floor = 2'd3;

  sched_res_t expected_q[$];
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_tmo = 0;
  int n_rej = 0;
  int send_idle = 29;
  int recv_idle = 78;
  int quiet = 0;

  function automatic sched_res_t mk(logic [2:0] k, logic [3:0] id, logic [1:0] l,
                                    logic [15:0] t, logic last);
    sched_res_t r;
    r.kind = k; r.id = id; r.lvl = l; r.t = t; r.last = last;
    return r;
  endfunction

  function automatic void schedule_req(logic [1:0] act, logic [3:0] id, logic [1:0] lvl_in,
                                       logic dem, logic [15:0] at, logic [15:0] now);
    int unsigned lvl, fl, pos, n;
    bit mark [LEVELS][TASKS];
    int w;
    lvl = lvl_in;
    n = 0;
    case (act)
      ACT_ADD: begin
        fl = (m_floor > LEVELS - 1) ? LEVELS - 1 : m_floor;
        if (dem && lvl != 0 && lvl < fl) lvl++;
        if (lvl >= LEVELS || q_cnt[lvl] >= TASKS) begin
          expected_q.push_back(mk(KIND_REJ, id, 2'(lvl), at, 1'b1));
          n_rej++;
        end else begin
          pos = q_cnt[lvl];
          while (pos > 0) begin
            if (q_t[lvl][pos-1] < at) break;
            if (q_t[lvl][pos-1] == at && q_id[lvl][pos-1] <= id) break;
            q_id[lvl][pos] = q_id[lvl][pos-1];
            q_t[lvl][pos] = q_t[lvl][pos-1];
            pos--;
          end
          q_id[lvl][pos] = id;
          q_t[lvl][pos] = at;
          q_cnt[lvl]++;
          expected_q.push_back(mk(KIND_ADDED, id, 2'(lvl), at, 1'b1));
        end
      end
      ACT_DISP: begin
        for (int l = 0; l < LEVELS; l++) begin
          if (q_cnt[l] > 0) begin
            expected_q.push_back(mk(KIND_DISP, q_id[l][0], 2'(l), q_t[l][0], 1'b1));
            for (int i = 0; i + 1 < q_cnt[l]; i++) begin
              q_id[l][i] = q_id[l][i+1];
              q_t[l][i] = q_t[l][i+1];
            end
            q_cnt[l]--;
            return;
          end
        end
        expected_q.push_back(mk(KIND_EMPTY, 0, 0, 0, 1'b1));
      end
      ACT_TMO: begin
        for (int l = 0; l < LEVELS; l++)
          for (int i = 0; i < TASKS; i++) mark[l][i] = 0;
        for (int k = 0; k < 16; k++)
          for (int l = 0; l < LEVELS; l++)
            for (int i = 0; i < q_cnt[l]; i++)
              if (q_id[l][i] == k && n < MAX_RES &&
                  {16'd0, q_t[l][i]} + {16'd0, m_limit} <= {16'd0, now}) begin
                mark[l][i] = 1;
                expected_q.push_back(mk(KIND_TMO, q_id[l][i], 2'(l), q_t[l][i], 1'b0));
                n++;
              end
        for (int l = 0; l < LEVELS; l++) begin
          w = 0;
          for (int i = 0; i < q_cnt[l]; i++)
            if (!mark[l][i]) begin
              q_id[l][w] = q_id[l][i];
              q_t[l][w] = q_t[l][i];
              w++;
            end
          q_cnt[l] = w;
        end
        if (n == 0) expected_q.push_back(mk(KIND_NOTMO, 0, 0, 0, 1'b1));
        else begin
          expected_q[$].last = 1'b1;
          n_tmo += n;
        end
      end
      default: ;
    endcase
  endfunction

  // result checking
  always @(posedge clk) begin
    sched_res_t got, exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = mk(out_tuser, out_tdata[3:0], out_tdata[5:4], out_tdata[21:6], out_tlast);
        n_res++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n ||
        cfg_psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] act, logic [3:0] id, logic [1:0] lvl, logic dem,
                          logic [15:0] at, logic [15:0] now);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {1'b0, now, at, dem, lvl, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    schedule_req(act, id, lvl, dem, at, now);
    if (act != ACT_NOP) n_req++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic cfg_write(logic reg_idx, logic [31:0] val);
    drain();
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (reg_idx == REG_LIMIT) m_limit = val[15:0];
    else m_floor = val[1:0];
    @(posedge clk);
  endtask

  task automatic rand_phase(int cnt);
    logic [1:0] act;
    int r;
    for (int k = 0; k < cnt; k++) begin
      r = $urandom_range(99);
      act = (r < 55) ? ACT_ADD : (r < 80) ? ACT_DISP : (r < 97) ? ACT_TMO : ACT_NOP;
      send_req(act, 4'($urandom), 2'($urandom), 1'($urandom), 16'($urandom_range(0, 300)),
               16'($urandom_range(0, 400)) |
               (($urandom_range(30) == 0) ? 16'hff00 : 16'h0));
    end
  endtask

  req_row_t dir_rows[$];

  task automatic add_row(logic [1:0] a, logic [3:0] id, logic [1:0] l, logic d,
                         logic [15:0] at, logic [15:0] now, logic fx, sched_res_t r);
    req_row_t row;
    row.act = a; row.id = id; row.lvl = l; row.dem = d; row.at = at; row.now = now;
    row.fixed = fx; row.res = r;
    dir_rows.push_back(row);
  endtask

  initial begin
    sched_res_t none;
    none = '0;
    for (int l = 0; l < LEVELS; l++) q_cnt[l] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(ACT_DISP, 0, 0, 0, 0, 0, 1, mk(KIND_EMPTY, 0, 0, 0, 1));
    add_row(ACT_TMO, 0, 0, 0, 0, 16'hffff, 1, mk(KIND_NOTMO, 0, 0, 0, 1));
    add_row(ACT_ADD, 15, 3, 1, 16'hffff, 0, 1, mk(KIND_ADDED, 15, 3, 16'hffff, 1));
    add_row(ACT_ADD, 0, 0, 1, 16'h0000, 0, 1, mk(KIND_ADDED, 0, 0, 16'h0000, 1));
    add_row(ACT_ADD, 5, 1, 1, 10, 0, 1, mk(KIND_ADDED, 5, 2, 10, 1));
    add_row(ACT_ADD, 4, 2, 0, 10, 0, 0, none);
    add_row(ACT_ADD, 4, 2, 0, 10, 0, 0, none);
    add_row(ACT_ADD, 3, 2, 0, 5, 0, 0, none);
    add_row(ACT_NOP, 1, 1, 1, 1, 1, 0, none);
    add_row(ACT_DISP, 0, 0, 0, 0, 0, 1, mk(KIND_DISP, 0, 0, 0, 1));
    add_row(ACT_DISP, 0, 0, 0, 0, 0, 0, none);
    add_row(ACT_TMO, 0, 0, 0, 0, 30, 0, none);
    add_row(ACT_TMO, 0, 0, 0, 0, 16'hffff, 0, none);
    for (int i = 0; i < 17; i++) add_row(ACT_ADD, 4'(i), 1, 0, 16'(100 - i), 0, 0, none);
    add_row(ACT_TMO, 0, 0, 0, 0, 16'hffff, 0, none);
    add_row(ACT_TMO, 0, 0, 0, 0, 16'hffff, 0, none);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].act, dir_rows[i].id, dir_rows[i].lvl, dir_rows[i].dem,
               dir_rows[i].at, dir_rows[i].now);
      if (dir_rows[i].fixed && dir_rows[i].res !== expected_q[$]) begin
        errors++;
        if (errors <= 10) $display("model row %0d: expected %p", i, dir_rows[i].res);
      end
    end

    cfg_write(REG_FLOOR, 0);
    send_req(ACT_ADD, 7, 1, 1, 3, 0);
    cfg_write(REG_LIMIT, 1);
    send_req(ACT_TMO, 0, 0, 0, 0, 4);
    cfg_write(REG_LIMIT, 16'hffff);
    cfg_write(REG_FLOOR, 1);
    rand_phase(150);
    cfg_write(REG_LIMIT, 37);
    cfg_write(REG_FLOOR, 2);
    send_idle = 78; recv_idle = 29;
    rand_phase(150);
    cfg_write(REG_LIMIT, 120);
    cfg_write(REG_FLOOR, 3);
    send_idle = 0; recv_idle = 0;
    rand_phase(130);
    drain();
    $display("requests %0d, results %0d, timeouts %0d, rejects %0d, limits 1..65535",
             n_req, n_res, n_tmo, n_rej);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mlqs_pkg.sv
hw/rtl/mlqs_ram.sv
hw/rtl/mlqs_ctrl.sv
hw/rtl/mlqs_dpath.sv
hw/rtl/multilevel_queue_scheduler.sv
hw/rtl/mlqs_chk.sv
test/tb_multilevel_queue_scheduler.sv
